@@ design/imu_lever_arm_compensation_assert.svh @@
// Assertion macros for the lever-arm compensation pipeline, used by the cross-product stage.
`ifndef IMU_LEVER_ARM_COMPENSATION_ASSERT_SVH
`define IMU_LEVER_ARM_COMPENSATION_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define ILAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define ILAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ilac_pkg.sv @@
// Types, constants and helper functions for the lever-arm compensation block.
package ilac_pkg;

  localparam int DATA_W    = 32;  // Q16.16 sample and result fields
  localparam int COEF_W    = 16;  // Q2.14 rotation entries and Q4.12 arm entries
  localparam int CFG_W     = 48;  // three packed entries per register
  localparam int CFG_IDX_W = 8;
  localparam int AB_W      = 36;  // rotated acceleration kept unsaturated
  localparam int C_W       = 50;  // rounded centripetal term
  localparam int SAT_IN_W  = 64;
  localparam int ROT_SHIFT = 14;
  localparam int ARM_SHIFT = 12;
  localparam int CEN_SHIFT = 16;

  typedef logic signed [DATA_W-1:0] s32_t;
  typedef s32_t [2:0]               vec32_t;
  typedef logic signed [AB_W-1:0]   ab_t;
  typedef ab_t [2:0]                vecab_t;
  typedef logic signed [C_W-1:0]    cw_t;
  typedef cw_t [2:0]                vecc_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;
  typedef cfg_word_t [2:0]          rot_mat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW_X = 8'd0,
    REG_ROT_ROW_Y = 8'd1,
    REG_ROT_ROW_Z = 8'd2,
    REG_LEVER_ARM = 8'd3
  } reg_idx_t;

  // Identity rotation and zero arm after reset.
  localparam cfg_word_t ROT_ROW_X_RST = 48'h0000_0000_4000;
  localparam cfg_word_t ROT_ROW_Y_RST = 48'h0000_4000_0000;
  localparam cfg_word_t ROT_ROW_Z_RST = 48'h4000_0000_0000;
  localparam cfg_word_t LEVER_ARM_RST = 48'h0000_0000_0000;

  // Clamp a signed value to the signed 32-bit range.
  function automatic s32_t sat32(input logic signed [SAT_IN_W-1:0] x);
    logic fits;
    fits = (&x[SAT_IN_W-1:DATA_W-1]) || !(|x[SAT_IN_W-1:DATA_W-1]);
    if (fits) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_IN_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/ilac_in_if.sv @@
// Sample channel: valid/ready handshake carrying one sensor-frame IMU sample.
interface ilac_in_if;
  import ilac_pkg::*;

  logic valid;
  logic ready;
  s32_t acc_x;
  s32_t acc_y;
  s32_t acc_z;
  s32_t gyro_x;
  s32_t gyro_y;
  s32_t gyro_z;

  modport source (
    output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
    output ready
  );
endinterface

@@ design/ilac_out_if.sv @@
// Result channel: valid/ready handshake carrying one body-frame result.
interface ilac_out_if;
  import ilac_pkg::*;

  logic valid;
  logic ready;
  s32_t body_acc_x;
  s32_t body_acc_y;
  s32_t body_acc_z;
  s32_t body_rate_x;
  s32_t body_rate_y;
  s32_t body_rate_z;

  modport source (
    output valid, body_acc_x, body_acc_y, body_acc_z,
           body_rate_x, body_rate_y, body_rate_z,
    input  ready
  );
  modport sink (
    input  valid, body_acc_x, body_acc_y, body_acc_z,
           body_rate_x, body_rate_y, body_rate_z,
    output ready
  );
endinterface

@@ design/ilac_cfg_if.sv @@
// Configuration write channel: register index and write data with valid/ready.
interface ilac_cfg_if;
  import ilac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  cfg_word_t            data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/ilac_rotate.sv @@
// Two-stage sensor-to-body rotation of the acceleration and rate vectors.
module ilac_rotate (
  input  logic              clk,
  input  logic              rst_n,
  input  ilac_pkg::rot_mat_t rot,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilac_pkg::vec32_t  in_acc,
  input  ilac_pkg::vec32_t  in_gyro,
  output logic              out_valid,
  input  logic              out_ready,
  output ilac_pkg::vecab_t  out_ab,
  output ilac_pkg::vec32_t  out_w
);
  import ilac_pkg::*;

  localparam int PROD_W = DATA_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - ROT_SHIFT;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(2 ** (ROT_SHIFT - 1));

  logic                     s1_v_r, s2_v_r;
  logic                     s1_ready, s2_ready;
  logic signed [PROD_W-1:0] pacc_r [3][3];
  logic signed [PROD_W-1:0] pgyr_r [3][3];
  logic signed [PROD_W-1:0] pacc_nxt [3][3];
  logic signed [PROD_W-1:0] pgyr_nxt [3][3];
  vecab_t                   ab_r, ab_nxt;
  vec32_t                   w_r, w_nxt;

  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Nine products per vector, one register after the multipliers.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pacc_nxt[r][c] = $signed(rot[r][COEF_W*c +: COEF_W]) * in_acc[c];
        pgyr_nxt[r][c] = $signed(rot[r][COEF_W*c +: COEF_W]) * in_gyro[c];
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sa, sg;
    logic signed [RND_W-1:0] ra, rg;
    for (int r = 0; r < 3; r++) begin
      sa = SUM_W'(pacc_r[r][0]) + SUM_W'(pacc_r[r][1]) + SUM_W'(pacc_r[r][2]) + HALF;
      sg = SUM_W'(pgyr_r[r][0]) + SUM_W'(pgyr_r[r][1]) + SUM_W'(pgyr_r[r][2]) + HALF;
      ra = RND_W'(sa >>> ROT_SHIFT);
      rg = RND_W'(sg >>> ROT_SHIFT);
      ab_nxt[r] = AB_W'(ra);
      w_nxt[r]  = sat32(SAT_IN_W'(rg));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      pacc_r <= pacc_nxt;
      pgyr_r <= pgyr_nxt;
    end
    if (s1_v_r && s2_ready) begin
      ab_r <= ab_nxt;
      w_r  <= w_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_ab    = ab_r;
  assign out_w     = w_r;

endmodule

@@ design/ilac_cross.sv @@
// Two-stage cross product w x b with rounding, carrying rate and acceleration along.
`include "imu_lever_arm_compensation_assert.svh"

module ilac_cross #(
  parameter int B_W    = 16,
  parameter int SHIFT  = 12,
  parameter int RES_W  = 32,
  parameter bit SAT_EN = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ilac_pkg::vec32_t      in_w,
  input  logic [2:0][B_W-1:0]   in_b,
  input  ilac_pkg::vecab_t      in_ab,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ilac_pkg::vec32_t      out_w,
  output ilac_pkg::vecab_t      out_ab,
  output logic [2:0][RES_W-1:0] out_res
);
  import ilac_pkg::*;

  localparam int P_W   = DATA_W + B_W;
  localparam int D_W   = P_W + 2;
  localparam int RND_W = D_W - SHIFT;
  localparam logic signed [D_W-1:0] HALF = D_W'(2 ** (SHIFT - 1));

  logic                    s1_v_r, s2_v_r;
  logic                    s1_ready, s2_ready;
  logic signed [P_W-1:0]   pa_r [3];
  logic signed [P_W-1:0]   pb_r [3];
  logic signed [P_W-1:0]   pa_nxt [3];
  logic signed [P_W-1:0]   pb_nxt [3];
  vec32_t                  w1_r, w2_r;
  vecab_t                  ab1_r, ab2_r;
  logic [2:0][RES_W-1:0]   res_r, res_nxt;
  logic signed [RND_W-1:0] rnd [3];

  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Component k is w[k+1]*b[k+2] - w[k+2]*b[k+1], indices taken modulo three.
  for (genvar k = 0; k < 3; k++) begin : g_comp
    localparam int P = (k + 1) % 3;
    localparam int Q = (k + 2) % 3;
    logic signed [D_W-1:0] diff;

    assign pa_nxt[k] = in_w[P] * $signed(in_b[Q]);
    assign pb_nxt[k] = in_w[Q] * $signed(in_b[P]);
    assign diff      = D_W'(pa_r[k]) - D_W'(pb_r[k]) + HALF;
    assign rnd[k]    = RND_W'(diff >>> SHIFT);

    if (SAT_EN) begin : g_sat
      assign res_nxt[k] = RES_W'(sat32(SAT_IN_W'(rnd[k])));
    end else begin : g_wide
      assign res_nxt[k] = RES_W'(rnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      w1_r  <= in_w;
      ab1_r <= in_ab;
    end
    if (s1_v_r && s2_ready) begin
      res_r <= res_nxt;
      w2_r  <= w1_r;
      ab2_r <= ab1_r;
    end
  end

  assign out_valid = s2_v_r;
  assign out_w     = w2_r;
  assign out_ab    = ab2_r;
  assign out_res   = res_r;

  `ILAC_ASSERT_NXT(a_s2_hold, s2_v_r && !out_ready, s2_v_r && $stable(res_r), "stalled cross product lost or changed")
  `ILAC_ASSERT_NXT(a_s1_hold, s1_v_r && !s2_ready, s1_v_r, "first stage beat dropped during stall")
  `ILAC_ASSERT_NXT(a_fill, in_valid && s1_ready, s1_v_r, "accepted beat did not reach first stage")
  `ILAC_ASSERT_IMP(a_backpressure, !s1_ready, s1_v_r && s2_v_r && !out_ready, "input held off with a free stage")

endmodule

@@ design/ilac_out.sv @@
// Final stage: subtracts the centripetal term, saturates and holds the result beat.
module ilac_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ilac_pkg::vecab_t in_ab,
  input  ilac_pkg::vecc_t  in_c,
  input  ilac_pkg::vec32_t in_w,
  ilac_out_if.source       out_bus
);
  import ilac_pkg::*;

  logic   v_r;
  vec32_t acc_r, acc_nxt;
  vec32_t rate_r;

  assign in_ready = !v_r || out_bus.ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = sat32(SAT_IN_W'(in_ab[k]) - SAT_IN_W'(in_c[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_r  <= acc_nxt;
      rate_r <= in_w;
    end
  end

  assign out_bus.valid       = v_r;
  assign out_bus.body_acc_x  = acc_r[0];
  assign out_bus.body_acc_y  = acc_r[1];
  assign out_bus.body_acc_z  = acc_r[2];
  assign out_bus.body_rate_x = rate_r[0];
  assign out_bus.body_rate_y = rate_r[1];
  assign out_bus.body_rate_z = rate_r[2];

endmodule

@@ design/imu_lever_arm_compensation.sv @@
// Top level of the IMU lever-arm compensation pipeline with its configuration registers.
//
//   channel   direction  beat contents
//   in_bus    sink       acc_x/y/z, gyro_x/y/z (sensor frame, Q16.16)
//   out_bus   source     body_acc_x/y/z, body_rate_x/y/z (body frame, Q16.16)
//   cfg_bus   sink       index, data (48-bit register write)
//
// One sample enters per clock while the output is not stalled; each beat passes through
// rotation, arm cross product and centripetal cross product, each a multiplier stage
// followed by a rounding stage, and then the output register.
// Reset clears every stage valid bit and loads the identity rotation and a zero arm.
// A stalled output holds its beat; earlier stages keep filling until all seven are full.
// Configuration writes are taken on every cycle.
module imu_lever_arm_compensation (
  input  logic       clk,
  input  logic       rst_n,
  ilac_in_if.sink    in_bus,
  ilac_out_if.source out_bus,
  ilac_cfg_if.sink   cfg_bus
);
  import ilac_pkg::*;

  rot_mat_t  rot_r, rot_nxt;
  cfg_word_t arm_r, arm_nxt;

  vec32_t    in_acc, in_gyro;
  logic      rot_valid, rot_ready;
  vecab_t    rot_ab;
  vec32_t    rot_w;
  logic      arm_valid, arm_ready;
  vecab_t    arm_ab;
  vec32_t    arm_w;
  vec32_t    arm_v;
  logic      cen_valid, cen_ready;
  vecab_t    cen_ab;
  vec32_t    cen_w;
  vecc_t     cen_c;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    rot_nxt = rot_r;
    arm_nxt = arm_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_ROT_ROW_X: rot_nxt[0] = cfg_bus.data;
        REG_ROT_ROW_Y: rot_nxt[1] = cfg_bus.data;
        REG_ROT_ROW_Z: rot_nxt[2] = cfg_bus.data;
        REG_LEVER_ARM: arm_nxt    = cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT_ROW_X_RST;
      rot_r[1] <= ROT_ROW_Y_RST;
      rot_r[2] <= ROT_ROW_Z_RST;
      arm_r    <= LEVER_ARM_RST;
    end else begin
      rot_r <= rot_nxt;
      arm_r <= arm_nxt;
    end
  end

  assign in_acc  = {in_bus.acc_z, in_bus.acc_y, in_bus.acc_x};
  assign in_gyro = {in_bus.gyro_z, in_bus.gyro_y, in_bus.gyro_x};

  ilac_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .rot       (rot_r),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_acc    (in_acc),
    .in_gyro   (in_gyro),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_ab    (rot_ab),
    .out_w     (rot_w)
  );

  // Tangential velocity v = w x r, saturated to 32 bits.
  ilac_cross #(
    .B_W    (COEF_W),
    .SHIFT  (ARM_SHIFT),
    .RES_W  (DATA_W),
    .SAT_EN (1'b1)
  ) u_arm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_w      (rot_w),
    .in_b      (arm_r),
    .in_ab     (rot_ab),
    .out_valid (arm_valid),
    .out_ready (arm_ready),
    .out_w     (arm_w),
    .out_ab    (arm_ab),
    .out_res   (arm_v)
  );

  // Centripetal term c = w x v, kept at full width until the final subtraction.
  ilac_cross #(
    .B_W    (DATA_W),
    .SHIFT  (CEN_SHIFT),
    .RES_W  (C_W),
    .SAT_EN (1'b0)
  ) u_cen (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (arm_valid),
    .in_ready  (arm_ready),
    .in_w      (arm_w),
    .in_b      (arm_v),
    .in_ab     (arm_ab),
    .out_valid (cen_valid),
    .out_ready (cen_ready),
    .out_w     (cen_w),
    .out_ab    (cen_ab),
    .out_res   (cen_c)
  );

  ilac_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (cen_valid),
    .in_ready (cen_ready),
    .in_ab    (cen_ab),
    .in_c     (cen_c),
    .in_w     (cen_w),
    .out_bus  (out_bus)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the IMU lever-arm compensation block, predicted beat by beat.
`timescale 1ns / 100ps

module testbench;
  import ilac_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int PIPE_DEPTH     = 7;
  localparam int TAIL_CYCLES    = PIPE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AFTER     = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 8'hFF;

  localparam s32_t S32_TOP    = 32'sh7FFF_FFFF;
  localparam s32_t S32_BOTTOM = 32'sh8000_0000;
  localparam s32_t S32_NEG_TOP = 32'sh8000_0001;
  localparam s32_t Q16_ONE    = 32'sh0001_0000;

  localparam logic [COEF_W-1:0] COEF_TOP     = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_BOTTOM  = 16'h8000;
  localparam logic [COEF_W-1:0] Q14_ONE      = 16'h4000;
  localparam logic [COEF_W-1:0] Q14_MINUS_ONE = 16'hC000;

  typedef logic signed [79:0] wide_t;
  localparam wide_t WIDE_S32_MAX = 80'sd2147483647;
  localparam wide_t WIDE_S32_MIN = -80'sd2147483648;

  typedef struct packed {
    s32_t acc_x;
    s32_t acc_y;
    s32_t acc_z;
    s32_t gyro_x;
    s32_t gyro_y;
    s32_t gyro_z;
  } imu_sample_t;

  typedef struct packed {
    s32_t body_acc_x;
    s32_t body_acc_y;
    s32_t body_acc_z;
    s32_t body_rate_x;
    s32_t body_rate_y;
    s32_t body_rate_z;
  } body_result_t;

  typedef struct packed {
    logic                 has_cfg;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_word_t            cfg_data;
    logic                 has_sample;
    imu_sample_t          sample;
    logic                 typed;
    body_result_t         want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ilac_in_if  in_bus ();
  ilac_out_if out_bus ();
  ilac_cfg_if cfg_bus ();

  imu_lever_arm_compensation u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Shadow copy of the register file.
  cfg_word_t rot_rows [3] = '{ROT_ROW_X_RST, ROT_ROW_Y_RST, ROT_ROW_Z_RST};
  cfg_word_t arm_word_now = LEVER_ARM_RST;

  reg_idx_t reg_order [4] = '{REG_ROT_ROW_X, REG_ROT_ROW_Y, REG_ROT_ROW_Z, REG_LEVER_ARM};
  string field_names [6] = '{"body_acc_x", "body_acc_y", "body_acc_z",
                             "body_rate_x", "body_rate_y", "body_rate_z"};

  body_result_t  body_frames_in_flight [$];
  directed_row_t steps [$];
  logic          beat_typed;
  body_result_t  beat_want;
  int            mismatches   = 0;
  int            results_seen = 0;
  int            idle_cycles  = 0;

  function automatic wide_t round_half_up(wide_t x, int s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic wide_t clamp32(wide_t x);
    if (x > WIDE_S32_MAX) return WIDE_S32_MAX;
    if (x < WIDE_S32_MIN) return WIDE_S32_MIN;
    return x;
  endfunction

  function automatic wide_t coef_of(cfg_word_t word, int k);
    wide_t c;
    c = $signed(word[COEF_W*k +: COEF_W]);
    return c;
  endfunction

  // Rotate both vectors, then take the centripetal term off the acceleration.
  // Everything is held at 80 bits so that no intermediate product can wrap.
  function automatic body_result_t to_body_frame(imu_sample_t s);
    wide_t acc [3];
    wide_t gyr [3];
    wide_t arm [3];
    wide_t ab [3];
    wide_t w [3];
    wide_t v [3];
    wide_t c [3];
    wide_t sa;
    wide_t sg;
    wide_t m;
    wide_t t;
    body_result_t r;
    acc[0] = s.acc_x;
    acc[1] = s.acc_y;
    acc[2] = s.acc_z;
    gyr[0] = s.gyro_x;
    gyr[1] = s.gyro_y;
    gyr[2] = s.gyro_z;
    for (int i = 0; i < 3; i++) begin
      arm[i] = coef_of(arm_word_now, i);
      sa = 0;
      sg = 0;
      for (int j = 0; j < 3; j++) begin
        m  = coef_of(rot_rows[i], j);
        sa = sa + m * acc[j];
        sg = sg + m * gyr[j];
      end
      ab[i] = round_half_up(sa, ROT_SHIFT);
      w[i]  = clamp32(round_half_up(sg, ROT_SHIFT));
    end
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp32(round_half_up(w[(i+1)%3] * arm[(i+2)%3] - w[(i+2)%3] * arm[(i+1)%3],
                                   ARM_SHIFT));
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = round_half_up(w[(i+1)%3] * v[(i+2)%3] - w[(i+2)%3] * v[(i+1)%3], CEN_SHIFT);
    end
    for (int i = 0; i < 3; i++) begin
      t = clamp32(ab[i] - c[i]);
      r[DATA_W*(5-i) +: DATA_W] = t[DATA_W-1:0];
      r[DATA_W*(2-i) +: DATA_W] = w[i][DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic directed_row_t cfg_step(logic [CFG_IDX_W-1:0] idx, cfg_word_t word);
    directed_row_t r;
    r           = '0;
    r.has_cfg   = 1'b1;
    r.cfg_index = idx;
    r.cfg_data  = word;
    return r;
  endfunction

  function automatic directed_row_t sample_step(imu_sample_t s, logic typed,
                                                body_result_t want);
    directed_row_t r;
    r            = '0;
    r.has_sample = 1'b1;
    r.sample     = s;
    r.typed      = typed;
    r.want       = want;
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic s32_t pick_field();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 75) return s32_t'($urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000);
    if (r < 84) return S32_TOP;
    if (r < 92) return S32_BOTTOM;
    return s32_t'($urandom_range(0, 8) - 4);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(logic for_arm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return COEF_TOP;
    if (r < 20) return COEF_BOTTOM;
    if (r < 30) return '0;
    if (!for_arm && r < 40) return Q14_ONE;
    if (!for_arm && r < 50) return Q14_MINUS_ONE;
    // Half a unit for rotation, two units for arm; most results stay unsaturated.
    if (r < 75) return COEF_W'($urandom_range(0, 16'h3FFF) - 16'h2000);
    return COEF_W'($urandom);
  endfunction

  function automatic cfg_word_t pick_word(logic for_arm);
    return {pick_coef(for_arm), pick_coef(for_arm), pick_coef(for_arm)};
  endfunction

  task automatic offer_sample(input imu_sample_t s, input logic typed,
                              input body_result_t want);
    in_bus.valid  <= 1'b1;
    in_bus.acc_x  <= s.acc_x;
    in_bus.acc_y  <= s.acc_y;
    in_bus.acc_z  <= s.acc_z;
    in_bus.gyro_x <= s.gyro_x;
    in_bus.gyro_y <= s.gyro_y;
    in_bus.gyro_z <= s.gyro_z;
    beat_typed    <= typed;
    beat_want     <= want;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic idle_inputs(input int cycles);
    if (cycles > 0) begin
      in_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t word);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (body_frames_in_flight.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= word;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    imu_sample_t s;
    cfg_word_t   rot_word [3];
    cfg_word_t   arm_word;
    int          n;
    int          start;
    int          k;
    logic        burst;
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.acc_x  <= '0;
    in_bus.acc_y  <= '0;
    in_bus.acc_z  <= '0;
    in_bus.gyro_x <= '0;
    in_bus.gyro_y <= '0;
    in_bus.gyro_z <= '0;
    beat_typed    <= 1'b0;
    beat_want     <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Identity after reset passes every sample through unchanged.
    s = '0;
    steps.push_back(sample_step(s, 1'b1, body_result_t'(s)));
    s = {6{S32_TOP}};
    steps.push_back(sample_step(s, 1'b1, body_result_t'(s)));
    s = {6{S32_BOTTOM}};
    steps.push_back(sample_step(s, 1'b1, body_result_t'(s)));
    s = {S32_TOP, S32_BOTTOM, 32'sd1, -32'sd1, 32'sd0, 32'sh1234_5678};
    steps.push_back(sample_step(s, 1'b1, body_result_t'(s)));
    // A write to an index past the last register must leave the identity in place.
    steps.push_back(cfg_step(REG_LAST_UNUSED, '1));
    s = {Q16_ONE, -Q16_ONE, Q16_ONE, -Q16_ONE, Q16_ONE, 32'sh00A5_5A00};
    steps.push_back(sample_step(s, 1'b1, body_result_t'(s)));
    // Negated identity: the most negative input saturates to the top.
    steps.push_back(cfg_step(REG_ROT_ROW_X, {32'h0, Q14_MINUS_ONE}));
    steps.push_back(cfg_step(REG_ROT_ROW_Y, {16'h0, Q14_MINUS_ONE, 16'h0}));
    steps.push_back(cfg_step(REG_ROT_ROW_Z, {Q14_MINUS_ONE, 32'h0}));
    steps.push_back(sample_step({6{S32_BOTTOM}}, 1'b1, {6{S32_TOP}}));
    steps.push_back(sample_step({6{S32_TOP}}, 1'b1, {6{S32_NEG_TOP}}));
    steps.push_back(cfg_step(REG_ROT_ROW_X, {3{COEF_TOP}}));
    steps.push_back(cfg_step(REG_ROT_ROW_Y, {3{COEF_TOP}}));
    steps.push_back(cfg_step(REG_ROT_ROW_Z, {3{COEF_TOP}}));
    steps.push_back(sample_step({6{S32_TOP}}, 1'b0, '0));
    steps.push_back(sample_step({6{S32_BOTTOM}}, 1'b0, '0));
    steps.push_back(cfg_step(REG_ROT_ROW_X, {3{COEF_BOTTOM}}));
    steps.push_back(cfg_step(REG_ROT_ROW_Y, {3{COEF_BOTTOM}}));
    steps.push_back(cfg_step(REG_ROT_ROW_Z, {3{COEF_BOTTOM}}));
    steps.push_back(sample_step({6{S32_TOP}}, 1'b0, '0));
    steps.push_back(sample_step({S32_BOTTOM, S32_TOP, S32_BOTTOM, S32_TOP, S32_BOTTOM,
                                 S32_TOP}, 1'b0, '0));
    steps.push_back(cfg_step(REG_LEVER_ARM, {3{COEF_TOP}}));
    steps.push_back(sample_step({96'h0, S32_TOP, S32_BOTTOM, S32_TOP}, 1'b0, '0));
    steps.push_back(cfg_step(REG_LEVER_ARM, {3{COEF_BOTTOM}}));
    steps.push_back(sample_step({6{S32_BOTTOM}}, 1'b0, '0));

    foreach (steps[i]) begin
      if (steps[i].has_cfg) write_register(steps[i].cfg_index, steps[i].cfg_data);
      if (steps[i].has_sample) begin
        offer_sample(steps[i].sample, steps[i].typed, steps[i].want);
        idle_inputs(pick_gap());
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int i = 0; i < 3; i++) rot_word[i] = pick_word(1'b0);
      // Now and then keep the identity so the arm term is seen on its own.
      if ($urandom_range(0, 4) == 0) rot_word = '{ROT_ROW_X_RST, ROT_ROW_Y_RST, ROT_ROW_Z_RST};
      arm_word = ($urandom_range(0, 3) == 0) ? LEVER_ARM_RST : pick_word(1'b1);
      start = $urandom_range(0, 3);
      for (int j = 0; j < 4; j++) begin
        k = (start + j) % 4;
        write_register(reg_order[k], (reg_order[k] == REG_LEVER_ARM) ? arm_word : rot_word[k]);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_register(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                       {16'($urandom), 32'($urandom)});
      end
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 60);
      repeat (n) begin
        s = {pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
             pick_field()};
        offer_sample(s, 1'b0, '0);
        idle_inputs(burst ? 0 : pick_gap());
      end
    end

    idle_inputs(1);
    @(posedge clk);
    while (body_frames_in_flight.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && body_frames_in_flight.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random back-pressure, calm stretches, and one long hold-off
  // taken while the sender is still offering, so that the pipeline fills and stalls.
  initial begin : result_sink
    int   stall;
    logic held_off;
    held_off = 1'b0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER && in_bus.valid) begin
        held_off = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_bus.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    body_result_t got;
    body_result_t want;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_ROT_ROW_X: rot_rows[0] = cfg_bus.data;
          REG_ROT_ROW_Y: rot_rows[1] = cfg_bus.data;
          REG_ROT_ROW_Z: rot_rows[2] = cfg_bus.data;
          REG_LEVER_ARM: arm_word_now = cfg_bus.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        if (beat_typed) begin
          body_frames_in_flight.push_back(beat_want);
        end else begin
          body_frames_in_flight.push_back(to_body_frame({in_bus.acc_x, in_bus.acc_y,
                                                         in_bus.acc_z, in_bus.gyro_x,
                                                         in_bus.gyro_y, in_bus.gyro_z}));
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.body_acc_x, out_bus.body_acc_y, out_bus.body_acc_z,
               out_bus.body_rate_x, out_bus.body_rate_y, out_bus.body_rate_z};
        results_seen++;
        if (body_frames_in_flight.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no sample outstanding, actual %h", $time, got);
        end else begin
          want = body_frames_in_flight.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (got[DATA_W*(5-f) +: DATA_W] !== want[DATA_W*(5-f) +: DATA_W]) begin
              mismatches++;
              $display("%0t: %s expected %h actual %h", $time, field_names[f],
                       want[DATA_W*(5-f) +: DATA_W], got[DATA_W*(5-f) +: DATA_W]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
